@@ design/bbrt_pkg.sv @@
// Shared constants and types of the bad block remap table.
// No dependencies; every other design file imports this package.
`default_nettype none

package bbrt_pkg;

	localparam int MaxSpare    = 16;
	localparam int SpareIdxW   = $clog2(MaxSpare);
	localparam int SpareCntW   = $clog2(MaxSpare + 1);
	localparam int OffsetW     = 48;
	localparam int BlockW      = 32;
	localparam int CfgW        = 5;
	localparam int LogPosW     = 8;
	localparam int RecordBytes = 8;
	localparam int InBlockW    = 31;
	localparam int SumW        = OffsetW + 1;

	localparam logic [CfgW-1:0] SpareBlocksRst = CfgW'(8);
	localparam logic [CfgW-1:0] BlockShiftRst  = CfgW'(12);

	typedef enum logic {
		KindTranslate = 1'b0,
		KindRemap     = 1'b1
	} kind_t;

	typedef enum logic {
		StatusOk      = 1'b0,
		StatusNoSpare = 1'b1
	} status_t;

	typedef enum logic [0:0] {
		RegSpareBlocks = 1'b0,
		RegBlockShift  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic load_in;
		logic calc_addr;
		logic finish;
	} bbrt_cmd_t;

	typedef struct packed {
		logic out_free;
	} bbrt_stat_t;

endpackage

`default_nettype wire

@@ design/bbrt_if.sv @@
// Valid/ready channels for requests and results of the remap table.
// Depends on bbrt_pkg for the field widths.
`default_nettype none

interface bbrt_in_if import bbrt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [OffsetW-1:0]       offset;

	modport source (output valid, output kind, output offset, input ready);
	modport sink   (input valid, input kind, input offset, output ready);
endinterface

interface bbrt_out_if import bbrt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OffsetW-1:0]       phys_offset;
	logic                     status;
	logic                     log_write;
	logic [LogPosW-1:0]       log_offset;
	logic [BlockW-1:0]        log_block;

	modport source (output valid, output phys_offset, output status, output log_write,
		output log_offset, output log_block, input ready);
	modport sink   (input valid, input phys_offset, input status, input log_write,
		input log_offset, input log_block, output ready);
endinterface

`default_nettype wire

@@ design/bbrt_ctrl.sv @@
// Sequencer of the remap table: accept, address, match/commit.
// Depends on bbrt_pkg for the command and status structs.
`default_nettype none

module bbrt_ctrl import bbrt_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire bbrt_stat_t stat,
	output bbrt_cmd_t       cmd
);

	typedef enum logic [1:0] {
		Idle,
		Addr,
		Match
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= Idle;
		end else begin
			unique case (state_q)
				Idle: begin
					if (in_valid) state_q <= Addr;
				end
				Addr: begin
					state_q <= Match;
				end
				Match: begin
					if (stat.out_free) state_q <= Idle;
				end
				default: begin
					state_q <= Idle;
				end
			endcase
		end
	end

	always_comb begin
		in_ready      = (state_q == Idle);
		cmd.load_in   = (state_q == Idle) && in_valid;
		cmd.calc_addr = (state_q == Addr);
		cmd.finish    = (state_q == Match) && stat.out_free;
	end

`ifndef SYNTHESIS
	a_accept_to_addr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> state_q == Addr)
		else $error("accepted request did not advance to address stage");
`endif

endmodule

`default_nettype wire

@@ design/bbrt_dp.sv @@
// Datapath of the remap table: configuration, address arithmetic,
// remap entries with parallel match, spare and log counters, result register.
// Depends on bbrt_pkg.
`default_nettype none

module bbrt_dp import bbrt_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire bbrt_cmd_t            cmd,
	output bbrt_stat_t                stat,
	input  wire logic                 cfg_we,
	input  wire cfg_reg_t             cfg_index,
	input  wire logic [CfgW-1:0]      cfg_data,
	input  wire logic                 in_kind,
	input  wire logic [OffsetW-1:0]   in_offset,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic [OffsetW-1:0]        out_phys_offset,
	output logic                      out_status,
	output logic                      out_log_write,
	output logic [LogPosW-1:0]        out_log_offset,
	output logic [BlockW-1:0]         out_log_block
);

	logic [CfgW-1:0]      spare_blocks_q;
	logic [CfgW-1:0]      block_shift_q;
	logic [SpareCntW-1:0] next_spare_q;
	logic [LogPosW-1:0]   log_pos_q;
	logic [BlockW-1:0]    remap_q [MaxSpare];

	logic                 kind_s1;
	logic [OffsetW-1:0]   offset_s1;
	logic                 kind_s2;
	logic [BlockW-1:0]    blk_s2;
	logic [InBlockW-1:0]  in_block_s2;
	logic [OffsetW-1:0]   sh_s2;

	logic                 out_valid_q;
	logic [OffsetW-1:0]   phys_q;
	logic                 status_q;
	logic                 log_write_q;
	logic [LogPosW-1:0]   log_offset_q;
	logic [BlockW-1:0]    log_block_q;

	logic [SumW-1:0]      sum;
	logic [SumW-1:0]      in_mask;
	logic                 hit;
	logic [SpareIdxW-1:0] hit_idx;
	logic [SpareIdxW-1:0] sel_idx;
	logic [OffsetW-1:0]   spare_offset;
	logic                 exhausted;
	logic                 do_remap;

	// Address arithmetic
	always_comb begin
		sum     = {1'b0, offset_s1} + (SumW'(spare_blocks_q) << block_shift_q);
		in_mask = (SumW'(1) << block_shift_q) - SumW'(1);
	end

	// Newest matching spare wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int j = 1; j < MaxSpare; j++) begin
			if (SpareCntW'(j) < next_spare_q && remap_q[j] == blk_s2) begin
				hit     = 1'b1;
				hit_idx = SpareIdxW'(j);
			end
		end
	end

	always_comb begin
		exhausted    = (next_spare_q >= SpareCntW'(spare_blocks_q)) ||
			(next_spare_q >= SpareCntW'(MaxSpare));
		do_remap     = cmd.finish && (kind_s2 == KindRemap) && !exhausted;
		sel_idx      = (kind_s2 == KindRemap) ? next_spare_q[SpareIdxW-1:0] : hit_idx;
		spare_offset = (OffsetW'(sel_idx) << block_shift_q) + OffsetW'(in_block_s2);
		stat.out_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spare_blocks_q <= SpareBlocksRst;
			block_shift_q  <= BlockShiftRst;
			next_spare_q   <= SpareCntW'(1);
			log_pos_q      <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					RegSpareBlocks: spare_blocks_q <= cfg_data;
					RegBlockShift:  block_shift_q  <= cfg_data;
					default: ;
				endcase
			end
			if (do_remap) begin
				next_spare_q <= next_spare_q + SpareCntW'(1);
				log_pos_q    <= log_pos_q + LogPosW'(RecordBytes);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_s1   <= in_kind;
			offset_s1 <= in_offset;
		end
		if (cmd.calc_addr) begin
			kind_s2     <= kind_s1;
			blk_s2      <= BlockW'(sum >> block_shift_q);
			in_block_s2 <= InBlockW'(sum & in_mask);
			sh_s2       <= sum[OffsetW-1:0];
		end
		if (do_remap) begin
			remap_q[next_spare_q[SpareIdxW-1:0]] <= blk_s2;
		end
		if (cmd.finish) begin
			phys_q       <= '0;
			status_q     <= StatusOk;
			log_write_q  <= 1'b0;
			log_offset_q <= '0;
			log_block_q  <= '0;
			if (kind_s2 == KindTranslate) begin
				phys_q <= hit ? spare_offset : sh_s2;
			end else if (exhausted) begin
				status_q <= StatusNoSpare;
			end else begin
				phys_q       <= spare_offset;
				log_write_q  <= 1'b1;
				log_offset_q <= log_pos_q;
				log_block_q  <= blk_s2;
			end
		end
	end

	always_comb begin
		out_valid       = out_valid_q;
		out_phys_offset = phys_q;
		out_status      = status_q;
		out_log_write   = log_write_q;
		out_log_offset  = log_offset_q;
		out_log_block   = log_block_q;
	end

`ifndef SYNTHESIS
	a_next_spare_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_spare_q >= SpareCntW'(1) && next_spare_q <= SpareCntW'(MaxSpare))
		else $error("next spare index out of range");
	a_log_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		log_pos_q[$clog2(RecordBytes)-1:0] == '0)
		else $error("log position not record aligned");
	a_remap_advance: assert property (@(posedge clk) disable iff (!arst_n)
		do_remap |=> next_spare_q == $past(next_spare_q) + SpareCntW'(1))
		else $error("successful remap did not advance the spare index");
	a_log_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && log_write_q |-> status_q == StatusOk)
		else $error("log record reported with no-spare status");
`endif

endmodule

`default_nettype wire

@@ design/bad_block_remap_table_core.sv @@
// Bad block remap table: offset translation past the spare area and
// remapping of failed blocks to spares. Built from bbrt_ctrl and bbrt_dp;
// depends on bbrt_pkg and the channel interfaces in bbrt_if.
//
// Usage:
//   in_ch carries requests: kind (translate or remap) and a 48-bit offset.
//   out_ch carries one result per request: physical offset, status, and for
//   a remap the log record position and the block number to record.
//   cfg_we/cfg_index/cfg_data write spare_blocks (index 0) and block_shift
//   (index 1); write them only while no request is in flight.
// Sequencing:
//   A request's result enters the output register once that register is
//   free. The sequencer handles one request at a time: accept, address
//   add/shift, then the 15-entry parallel match and commit. The next request
//   is taken while a finished result waits in the output register; if the
//   receiver stalls, the match step holds until it frees.
// Reset:
//   The remap table starts empty, next spare is 1, log position 0,
//   spare_blocks 8 and block_shift 12. No clearing pass is needed.
`default_nettype none

module bad_block_remap_table_core import bbrt_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	bbrt_in_if.sink               in_ch,
	bbrt_out_if.source            out_ch,
	input  wire logic             cfg_we,
	input  wire cfg_reg_t         cfg_index,
	input  wire logic [CfgW-1:0]  cfg_data
);

	bbrt_cmd_t  cmd;
	bbrt_stat_t stat;

	bbrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bbrt_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_kind         (in_ch.kind),
		.in_offset       (in_ch.offset),
		.out_ready       (out_ch.ready),
		.out_valid       (out_ch.valid),
		.out_phys_offset (out_ch.phys_offset),
		.out_status      (out_ch.status),
		.out_log_write   (out_ch.log_write),
		.out_log_offset  (out_ch.log_offset),
		.out_log_block   (out_ch.log_block)
	);

endmodule

`default_nettype wire
